/* rtl/grc_pkg.sv */
package grc_pkg;

  // Default geometry of the screen and of the grid map.
  localparam int unsigned SCREEN_W_DEF = 640;
  localparam int unsigned SCREEN_H_DEF = 480;
  localparam int unsigned MAP_SIZE_DEF = 16;

  // Fixed widths of the camera registers and of the shared divider.
  localparam int unsigned POS_W   = 16;
  localparam int unsigned DIR_W   = 16;
  localparam int unsigned FRAC_W  = 12;
  localparam int unsigned DIV_N_W = 27;
  localparam int unsigned DIV_D_W = 48;
  localparam int unsigned SD_W    = 48;

  // Stand-in for an infinite delta distance when a ray component is zero.
  localparam logic [SD_W-1:0] DIST_INF = 48'h0100_0000_0000;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAM_POS_X   = 3'd0,
    CFG_CAM_POS_Y   = 3'd1,
    CFG_VIEW_DIR_X  = 3'd2,
    CFG_VIEW_DIR_Y  = 3'd3,
    CFG_CAM_PLANE_X = 3'd4,
    CFG_CAM_PLANE_Y = 3'd5
  } cfg_idx_e;

  localparam logic [POS_W-1:0] CAM_POS_X_RST   = 16'h8000;
  localparam logic [POS_W-1:0] CAM_POS_Y_RST   = 16'h8000;
  localparam logic [DIR_W-1:0] VIEW_DIR_X_RST  = 16'hC000;
  localparam logic [DIR_W-1:0] VIEW_DIR_Y_RST  = 16'h0000;
  localparam logic [DIR_W-1:0] CAM_PLANE_X_RST = 16'h0000;
  localparam logic [DIR_W-1:0] CAM_PLANE_Y_RST = 16'd10813;

  // Item and result codes.
  localparam logic ITEM_WRITE = 1'b0;
  localparam logic ITEM_CAST  = 1'b1;
  localparam logic SIDE_X     = 1'b0;
  localparam logic SIDE_Y     = 1'b1;
  localparam logic ST_WALL    = 1'b0;
  localparam logic ST_OFF_MAP = 1'b1;

  typedef struct packed {
    logic       command;
    logic [9:0] column;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [3:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  out_column;
    logic [3:0]  wall_type;
    logic        hit_side;
    logic [15:0] wall_distance;
    logic [8:0]  draw_start;
    logic [8:0]  draw_end;
    logic        status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    DP_NONE,
    DP_CLEAR,
    DP_LATCH,
    DP_CAMX,
    DP_MUL,
    DP_RAY,
    DP_DIV_DX,
    DP_DIV_DY,
    DP_SIDE,
    DP_STEP,
    DP_DIV_LH,
    DP_HIT,
    DP_OFF_MAP
  } dp_op_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic item_cast;
    logic div_busy;
    logic off_map;
    logic cell_hit;
    logic step_limit;
    logic out_stall;
  } dp_status_t;

endpackage

/* rtl/grc_div.sv */
module grc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [grc_pkg::DIV_N_W-1:0]   dividend_i,
  input  logic [grc_pkg::DIV_D_W-1:0]   divisor_i,
  output logic                          busy_o,
  output logic [grc_pkg::DIV_N_W-1:0]   quotient_o
);

  localparam int unsigned NW   = grc_pkg::DIV_N_W;
  localparam int unsigned DW   = grc_pkg::DIV_D_W;
  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DW:0]     trial;
  logic            q_bit;

  // Restoring division, one quotient bit per cycle; the dividend shifts out
  // of the top of quo_q while quotient bits enter at the bottom.
  always_comb begin
    trial  = {rem_q, quo_q[NW-1]};
    q_bit  = (trial >= {1'b0, dvs_q});
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = q_bit ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
      quo_d  = {quo_q[NW-2:0], q_bit};
      cnt_d  = cnt_q - CntW'(1);
      busy_d = (cnt_q != CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/grc_dp.sv */
module grc_dp #(
  parameter int unsigned SCREEN_W = grc_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H = grc_pkg::SCREEN_H_DEF,
  parameter int unsigned MAP_SIZE = grc_pkg::MAP_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  grc_pkg::dp_op_e                op_i,
  output grc_pkg::dp_status_t            status_o,
  input  grc_pkg::in_item_t              in_data_i,
  input  logic                           cfg_we_i,
  input  logic [grc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [grc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output grc_pkg::out_item_t             out_data_o
);

  localparam int unsigned SdW   = grc_pkg::SD_W;
  localparam int unsigned NW    = grc_pkg::DIV_N_W;
  localparam int unsigned DW    = grc_pkg::DIV_D_W;
  localparam int unsigned QMax  = (1023 * 32768) / SCREEN_W;
  localparam int unsigned CamW  = $clog2(QMax + 1) + 2;
  localparam int unsigned ProdW = grc_pkg::DIR_W + CamW;
  localparam int unsigned RayW  = CamW + 3;
  localparam int unsigned MapW  = $clog2(16 + 2 * MAP_SIZE + 3) + 1;
  localparam int unsigned Limit = 2 * MAP_SIZE + 2;
  localparam int unsigned CntW  = $clog2(Limit + 1);
  localparam int unsigned Depth = MAP_SIZE * MAP_SIZE;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned XW    = $clog2(MAP_SIZE);
  localparam int unsigned LhW   = $clog2(2 * SCREEN_H + 1);
  // The column shifted up by 15 stays below 2^25, so a reciprocal with
  // 25 + log2(SCREEN_W) fraction bits gives the exact floor of the quotient.
  localparam int unsigned RecK  = 25 + $clog2(SCREEN_W);
  localparam logic [26:0] RecM  =
    27'(((64'd1 << RecK) + 64'(SCREEN_W) - 64'd1) / 64'(SCREEN_W));

  // Camera registers.
  logic [15:0]        pos_x_q, pos_y_q;
  logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

  // Cast working registers.
  logic [9:0]              col_q;
  logic signed [CamW-1:0]  camx_q;
  logic signed [ProdW-1:0] prod_x_q, prod_y_q;
  logic signed [RayW-1:0]  rx_q, ry_q;
  logic [SdW-1:0]          dx_q, dy_q, sdx_q, sdy_q, dist_q;
  logic signed [MapW-1:0]  mx_q, my_q;
  logic                    side_q;
  logic [CntW-1:0]         cnt_q;
  logic [3:0]              rd_data_q;
  logic [AW-1:0]           clr_q;
  logic                    out_valid_q;
  grc_pkg::out_item_t      out_q;

  logic [3:0] grid_mem [Depth];

  // Divider hookup.
  logic          div_start, div_busy;
  logic [NW-1:0] div_dvd, div_q;
  logic [DW-1:0] div_dvs;

  grc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quotient_o (div_q)
  );

  // Ray set-up.
  logic [36:0]             camx_prod;
  logic [CamW-3:0]         camx_u;
  logic signed [CamW-1:0]  camx;
  logic signed [ProdW-1:0] prod_x_d, prod_y_d;
  logic [RayW-1:0]         ax, ay;

  assign camx_prod = 37'(col_q) * 37'(RecM);
  assign camx_u    = (CamW - 2)'(camx_prod >> (RecK - 15));
  assign camx      = $signed({2'b00, camx_u}) - $signed(CamW'(16384));
  assign prod_x_d  = plane_x_q * camx_q;
  assign prod_y_d  = plane_y_q * camx_q;
  assign ax        = rx_q[RayW-1] ? RayW'(-rx_q) : RayW'(rx_q);
  assign ay        = ry_q[RayW-1] ? RayW'(-ry_q) : RayW'(ry_q);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (op_i)
      grc_pkg::DP_DIV_DX: begin
        div_start = 1'b1;
        div_dvd   = NW'(1) << 26;
        div_dvs   = DW'(ax);
      end
      grc_pkg::DP_DIV_DY: begin
        div_start = 1'b1;
        div_dvd   = NW'(1) << 26;
        div_dvs   = DW'(ay);
      end
      grc_pkg::DP_DIV_LH: begin
        div_start = 1'b1;
        div_dvd   = NW'(SCREEN_H * 4096);
        div_dvs   = dist_q;
      end
      default: ;
    endcase
  end

  // Initial side distances.
  logic [12:0] fx, fy;
  logic [39:0] mul_x, mul_y;
  logic [SdW-1:0] sdx_init, sdy_init;

  assign fx       = rx_q[RayW-1] ? {1'b0, pos_x_q[11:0]} : 13'd4096 - {1'b0, pos_x_q[11:0]};
  assign fy       = ry_q[RayW-1] ? {1'b0, pos_y_q[11:0]} : 13'd4096 - {1'b0, pos_y_q[11:0]};
  assign mul_x    = 40'(fx) * 40'(dx_q[26:0]);
  assign mul_y    = 40'(fy) * 40'(div_q[26:0]);
  assign sdx_init = (rx_q == '0) ? (SdW'(fx) << 28) : SdW'(mul_x >> 12);
  assign sdy_init = (ry_q == '0) ? (SdW'(fy) << 28) : SdW'(mul_y >> 12);

  // One DDA step.
  logic                   step_x;
  logic signed [MapW-1:0] nx, ny;
  logic [AW-1:0]          rd_addr;

  assign step_x  = (sdx_q < sdy_q);
  assign nx      = !step_x ? mx_q : (rx_q[RayW-1] ? mx_q - MapW'(1) : mx_q + MapW'(1));
  assign ny      = step_x ? my_q : (ry_q[RayW-1] ? my_q - MapW'(1) : my_q + MapW'(1));
  assign rd_addr = AW'(int'(nx[XW-1:0]) * MAP_SIZE + int'(ny[XW-1:0]));

  // Wall stripe rows.
  logic [LhW-1:0]        lh;
  logic signed [LhW:0]   half_s, mid_s, start_s, end_s, start_c, end_c;

  always_comb begin
    lh      = (div_q > NW'(2 * SCREEN_H)) ? LhW'(2 * SCREEN_H) : div_q[LhW-1:0];
    half_s  = $signed((LhW + 1)'(lh >> 1));
    mid_s   = $signed((LhW + 1)'(SCREEN_H / 2));
    start_s = mid_s - half_s;
    end_s   = mid_s + half_s;
    start_c = (start_s < 0) ? '0 : start_s;
    end_c   = (end_s > $signed((LhW + 1)'(SCREEN_H - 1))) ?
              $signed((LhW + 1)'(SCREEN_H - 1)) : end_s;
  end

  // Map writes: the clearing sweep or a cell write.
  logic          cell_ok, wr_en;
  logic [AW-1:0] wr_addr;
  logic [3:0]    wr_data;

  assign cell_ok = (int'(in_data_i.cell_x) < MAP_SIZE) && (int'(in_data_i.cell_y) < MAP_SIZE);
  assign wr_en   = (op_i == grc_pkg::DP_CLEAR) ||
                   ((op_i == grc_pkg::DP_LATCH) && (in_data_i.command == grc_pkg::ITEM_WRITE)
                    && cell_ok);
  assign wr_addr = (op_i == grc_pkg::DP_CLEAR) ? clr_q :
                   AW'(int'(in_data_i.cell_x) * MAP_SIZE + int'(in_data_i.cell_y));
  assign wr_data = (op_i == grc_pkg::DP_CLEAR) ? 4'd0 : in_data_i.cell_value;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
    if (op_i == grc_pkg::DP_STEP) begin
      rd_data_q <= grid_mem[rd_addr];
    end
  end

  // Control state and camera registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= grc_pkg::CAM_POS_X_RST;
      pos_y_q     <= grc_pkg::CAM_POS_Y_RST;
      dir_x_q     <= grc_pkg::VIEW_DIR_X_RST;
      dir_y_q     <= grc_pkg::VIEW_DIR_Y_RST;
      plane_x_q   <= grc_pkg::CAM_PLANE_X_RST;
      plane_y_q   <= grc_pkg::CAM_PLANE_Y_RST;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (grc_pkg::cfg_idx_e'(cfg_index_i))
          grc_pkg::CFG_CAM_POS_X:   pos_x_q   <= cfg_wdata_i;
          grc_pkg::CFG_CAM_POS_Y:   pos_y_q   <= cfg_wdata_i;
          grc_pkg::CFG_VIEW_DIR_X:  dir_x_q   <= cfg_wdata_i;
          grc_pkg::CFG_VIEW_DIR_Y:  dir_y_q   <= cfg_wdata_i;
          grc_pkg::CFG_CAM_PLANE_X: plane_x_q <= cfg_wdata_i;
          grc_pkg::CFG_CAM_PLANE_Y: plane_y_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (op_i == grc_pkg::DP_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if ((op_i == grc_pkg::DP_HIT) || (op_i == grc_pkg::DP_OFF_MAP)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Cast working registers.
  always_ff @(posedge clk_i) begin
    case (op_i)
      grc_pkg::DP_LATCH: col_q <= in_data_i.column;
      grc_pkg::DP_CAMX:  camx_q <= camx;
      grc_pkg::DP_MUL: begin
        prod_x_q <= prod_x_d;
        prod_y_q <= prod_y_d;
      end
      grc_pkg::DP_RAY: begin
        rx_q <= RayW'(dir_x_q) + RayW'(prod_x_q >>> 14);
        ry_q <= RayW'(dir_y_q) + RayW'(prod_y_q >>> 14);
      end
      grc_pkg::DP_DIV_DY: dx_q <= (rx_q == '0) ? grc_pkg::DIST_INF : SdW'(div_q);
      grc_pkg::DP_SIDE: begin
        dy_q  <= (ry_q == '0) ? grc_pkg::DIST_INF : SdW'(div_q);
        sdx_q <= sdx_init;
        sdy_q <= sdy_init;
        mx_q  <= MapW'(pos_x_q[15:12]);
        my_q  <= MapW'(pos_y_q[15:12]);
        cnt_q <= '0;
      end
      grc_pkg::DP_STEP: begin
        if (step_x) begin
          dist_q <= sdx_q;
          sdx_q  <= sdx_q + dx_q;
          side_q <= grc_pkg::SIDE_X;
        end else begin
          dist_q <= sdy_q;
          sdy_q  <= sdy_q + dy_q;
          side_q <= grc_pkg::SIDE_Y;
        end
        mx_q  <= nx;
        my_q  <= ny;
        cnt_q <= cnt_q + CntW'(1);
      end
      grc_pkg::DP_HIT: begin
        out_q.out_column    <= col_q;
        out_q.wall_type     <= rd_data_q;
        out_q.hit_side      <= side_q;
        out_q.wall_distance <= (dist_q > SdW'(65535)) ? 16'hFFFF : dist_q[15:0];
        out_q.draw_start    <= 9'(start_c);
        out_q.draw_end      <= 9'(end_c);
        out_q.status        <= grc_pkg::ST_WALL;
      end
      grc_pkg::DP_OFF_MAP: begin
        out_q.out_column    <= col_q;
        out_q.wall_type     <= 4'd0;
        out_q.hit_side      <= side_q;
        out_q.wall_distance <= 16'hFFFF;
        out_q.draw_start    <= 9'd0;
        out_q.draw_end      <= 9'd0;
        out_q.status        <= grc_pkg::ST_OFF_MAP;
      end
      default: ;
    endcase
  end

  assign status_o.clear_last = (clr_q == AW'(Depth - 1));
  assign status_o.item_cast  = (in_data_i.command == grc_pkg::ITEM_CAST);
  assign status_o.div_busy   = div_busy;
  assign status_o.off_map    = (mx_q < 0) || (mx_q >= $signed(MapW'(MAP_SIZE))) ||
                               (my_q < 0) || (my_q >= $signed(MapW'(MAP_SIZE)));
  assign status_o.cell_hit   = (rd_data_q != 4'd0);
  assign status_o.step_limit = (cnt_q == CntW'(Limit));
  assign status_o.out_stall  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/grc_ctrl.sv */
module grc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  grc_pkg::dp_status_t status_i,
  output grc_pkg::dp_op_e     op_o
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_CAMX,
    S_MUL,
    S_RAY,
    S_DX,
    S_DX_WAIT,
    S_DY,
    S_DY_WAIT,
    S_SIDE,
    S_STEP,
    S_TEST,
    S_LH,
    S_LH_WAIT,
    S_HIT,
    S_OFF
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = grc_pkg::DP_NONE;
    unique case (state_q)
      S_CLEAR: begin
        op_o = grc_pkg::DP_CLEAR;
        if (status_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_o = grc_pkg::DP_LATCH;
          if (status_i.item_cast) state_d = S_CAMX;
        end
      end
      S_CAMX: begin
        op_o    = grc_pkg::DP_CAMX;
        state_d = S_MUL;
      end
      S_MUL: begin
        op_o    = grc_pkg::DP_MUL;
        state_d = S_RAY;
      end
      S_RAY: begin
        op_o    = grc_pkg::DP_RAY;
        state_d = S_DX;
      end
      S_DX: begin
        op_o    = grc_pkg::DP_DIV_DX;
        state_d = S_DX_WAIT;
      end
      S_DX_WAIT: if (!status_i.div_busy) state_d = S_DY;
      S_DY: begin
        op_o    = grc_pkg::DP_DIV_DY;
        state_d = S_DY_WAIT;
      end
      S_DY_WAIT: if (!status_i.div_busy) state_d = S_SIDE;
      S_SIDE: begin
        op_o    = grc_pkg::DP_SIDE;
        state_d = S_STEP;
      end
      S_STEP: begin
        op_o    = grc_pkg::DP_STEP;
        state_d = S_TEST;
      end
      S_TEST: begin
        if (status_i.off_map) begin
          state_d = S_OFF;
        end else if (status_i.cell_hit) begin
          state_d = S_LH;
        end else if (status_i.step_limit) begin
          state_d = S_OFF;
        end else begin
          state_d = S_STEP;
        end
      end
      S_LH: begin
        op_o    = grc_pkg::DP_DIV_LH;
        state_d = S_LH_WAIT;
      end
      S_LH_WAIT: if (!status_i.div_busy) state_d = S_HIT;
      S_HIT: begin
        if (!status_i.out_stall) begin
          op_o    = grc_pkg::DP_HIT;
          state_d = S_IDLE;
        end
      end
      S_OFF: begin
        if (!status_i.out_stall) begin
          op_o    = grc_pkg::DP_OFF_MAP;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

/* rtl/grid_ray_cast_column.sv */
// Grid ray caster for one wall column.
// Input beats on in_valid_i/in_ready_o either write one cell of the grid
// map (command 0) or ask for one screen column to be cast (command 1). A
// write gives no result and the block is ready again in the next cycle.
// A cast gives exactly one result beat on out_valid_o/out_ready_i, in order.
// The camera registers are written through cfg_we_i, cfg_index_i and
// cfg_wdata_i; the user must write them only while no cast is in progress,
// as the block itself does not enforce this. A cast works out camera x by
// a reciprocal multiplication, runs divisions on one shared restoring
// divider (both delta distances and, for a hit, the line height), passes
// set-up and result states, then takes at most 2 * MAP_SIZE + 2 DDA steps.
// One cast is in flight at a time; the next beat is taken in the cycle
// after the result is registered. After reset the map is cleared one cell
// a cycle, all MAP_SIZE * MAP_SIZE cells (256 at the default size), while
// in_ready_o stays low.
// The result sits in an output register: when the receiver stalls, new
// items are still accepted and worked on, and only a finished cast waits
// until the previous result has been taken.
module grid_ray_cast_column #(
  parameter int unsigned SCREEN_W = grc_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H = grc_pkg::SCREEN_H_DEF,
  parameter int unsigned MAP_SIZE = grc_pkg::MAP_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  grc_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output grc_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [grc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [grc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  // Command and status between the sequencer and the datapath.
  grc_pkg::dp_op_e     op;
  grc_pkg::dp_status_t status;

  grc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .op_o       (op)
  );

  grc_dp #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H),
    .MAP_SIZE (MAP_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/grc_checker.sv */
module grc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input grc_pkg::out_item_t out_data_o
);

  // A stalled result beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // A ray that left the map reports the fixed miss values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == grc_pkg::ST_OFF_MAP) |->
      (out_data_o.wall_type == 4'd0) && (out_data_o.wall_distance == 16'hFFFF) &&
      (out_data_o.draw_start == 9'd0) && (out_data_o.draw_end == 9'd0))
    else $error("off-map result carries wall data");

  // A wall stripe never starts below its end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == grc_pkg::ST_WALL) |->
      out_data_o.draw_start <= out_data_o.draw_end)
    else $error("wall stripe rows out of order");

  // No result can follow an accepted input beat in the very next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared one cycle after an input beat");

endmodule

bind grid_ray_cast_column grc_checker u_checker (.*);
